@@ sv/jpeg2000_transform_detector_macros.svh @@
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JPEG2000_TRANSFORM_DETECTOR_MACROS_SVH
`define JPEG2000_TRANSFORM_DETECTOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define JP2TD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A condition that must be followed in the next cycle by a consequence.
`define JP2TD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/jp2td_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector package
// Parse phases, marker and box codes, status codes and shared structs.
// ----------------------------------------------------------------------------
package jp2td_pkg;

  // Parse phase of the byte walker.
  typedef enum logic [3:0] {
    PH_START,
    PH_BOXLEN,
    PH_BOXTYPE,
    PH_XLEN,
    PH_XLEN_CS,
    PH_BOXSKIP,
    PH_MARKER,
    PH_SEGLEN,
    PH_SEGLEN_COD,
    PH_SEGSKIP,
    PH_CODBODY,
    PH_DONE
  } phase_e;

  // Codestream markers and the contiguous codestream box type.
  localparam logic [15:0] MK_COD      = 16'hFF52;
  localparam logic [15:0] MK_SOD      = 16'hFF93;
  localparam logic [15:0] MK_SOC      = 16'hFF4F;
  localparam logic [15:0] MK_EOC      = 16'hFFD9;
  localparam logic [15:0] MK_EPH      = 16'hFF92;
  localparam logic [15:0] MK_RSV_LO   = 16'hFF30;
  localparam logic [15:0] MK_RSV_HI   = 16'hFF3F;
  localparam logic [31:0] BOX_JP2C    = 32'h6a703263;
  localparam logic [7:0]  RAW_CS_BYTE = 8'hFF;

  // Status codes of a result.
  localparam logic [1:0] ST_LOSSY     = 2'd0;
  localparam logic [1:0] ST_LOSSLESS  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_PARSE_ERR = 2'd3;

  // Transformation byte values in the COD segment.
  localparam logic [7:0] XFORM_IRREV = 8'd0;
  localparam logic [7:0] XFORM_REV   = 8'd1;

  // One input byte as held in the input register.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_stream;
  } item_t;

  // Result of one parse step.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } res_t;

  // Markers that are not followed by a segment length.
  function automatic logic no_length(input logic [15:0] m);
    logic reserved;
    reserved = (m >= MK_RSV_LO) && (m <= MK_RSV_HI);
    return reserved || (m == MK_SOC) || (m == MK_SOD) || (m == MK_EOC) || (m == MK_EPH);
  endfunction

endpackage

@@ sv/jp2td_byte_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector byte channel
// Valid/ready channel that carries one file byte and its end-of-stream flag.
// ----------------------------------------------------------------------------
interface jp2td_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_stream;

  modport source (output valid, output byte_value, output end_of_stream, input ready);
  modport sink (input valid, input byte_value, input end_of_stream, output ready);
  modport monitor (input valid, input byte_value, input end_of_stream, input ready);
endinterface

@@ sv/jp2td_status_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector status channel
// Valid/ready channel that carries the per-stream status result.
// ----------------------------------------------------------------------------
interface jp2td_status_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
  modport monitor (input valid, input status, input ready);
endinterface

@@ sv/jpeg2000_transform_detector.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector
// Reads a JP2 file or raw codestream byte by byte and reports whether the
// COD segment selects the lossless or the lossy wavelet transform.
//
//   Channel    Dir  Payload                       Transfer
//   byte_i     in   byte_value[7:0], end_of_stream valid && ready
//   status_o   out  status[1:0]                   valid && ready
//
// One byte per cycle unless a held result stalls the parser; a result passes
// the input register and the result register, and the walker updates its
// counters once per byte in the parser stage. A held result stalls the parser,
// but the input register still takes one more byte while the result waits.
// Reset clears both registers and returns the walker to the first byte.
// ----------------------------------------------------------------------------
module jpeg2000_transform_detector (
  input  logic           clk_i,
  input  logic           rst_ni,
  jp2td_byte_if.sink     byte_i,
  jp2td_status_if.source status_o
);
  import jp2td_pkg::*;

  logic  out_free;
  logic  step;
  item_t item;
  res_t  res;

  // Input register.
  jp2td_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_i     (byte_i),
    .out_free_i (out_free),
    .step_o     (step),
    .item_o     (item)
  );

  // Box and marker walker.
  jp2td_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .res_o  (res)
  );

  // Result register.
  jp2td_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .res_i    (res),
    .free_o   (out_free),
    .status_o (status_o)
  );

endmodule

@@ sv/jp2td_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector input stage
// Registers each incoming byte and hands it on when the parser steps.
// ----------------------------------------------------------------------------
module jp2td_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  jp2td_byte_if.sink      byte_i,
  input  logic            out_free_i,
  output logic            step_o,
  output jp2td_pkg::item_t item_o
);
  import jp2td_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The held byte is consumed whenever the result register has room.
  assign step_o       = valid_q && out_free_i;
  assign byte_i.ready = !valid_q || step_o;
  assign item_o       = item_q;

  // Valid flag of the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (byte_i.ready) begin
      valid_q <= byte_i.valid;
    end
  end

  // Payload of the input register, loaded on every transfer.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      item_q <= '{byte_value: byte_i.byte_value, end_of_stream: byte_i.end_of_stream};
    end
  end

endmodule

@@ sv/jp2td_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector parser
// Walks JP2 boxes and codestream markers one byte per step and decides the
// wavelet transform from the COD segment.
// ----------------------------------------------------------------------------
module jp2td_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  jp2td_pkg::item_t item_i,
  output jp2td_pkg::res_t  res_o
);
  import jp2td_pkg::*;

  phase_e      phase_q, phase_d;
  logic [63:0] field_q, field_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] skip_q, skip_d;
  logic [63:0] csrem_q, csrem_d;
  logic        bounded_q, bounded_d;
  logic        lossless_q, lossless_d;
  logic        decided_q, decided_d;

  logic [7:0]  b;
  logic        last;
  logic [63:0] shifted;
  logic [3:0]  cnt_inc;
  logic [63:0] skip_dec;
  logic [63:0] csrem_dec;
  logic        in_cs;

  // Box open: one subtract serves both the short and the extended length.
  logic [63:0] ob_len;
  logic [63:0] ob_sub;
  logic        ob_ok;
  logic [63:0] ob_payload;
  logic        ob_do;
  logic        ob_cs;
  logic        ob_to_end;

  logic        st_vld;
  logic [1:0]  st;
  logic [15:0] low16;
  logic [15:0] seg_rem;

  assign b          = item_i.byte_value;
  assign last       = item_i.end_of_stream;
  assign shifted    = {field_q[55:0], b};
  assign cnt_inc    = cnt_q + 4'd1;
  assign skip_dec   = skip_q - 64'd1;
  assign low16      = shifted[15:0];
  assign seg_rem    = low16 - 16'd2;
  assign ob_len     = (phase_q == PH_BOXTYPE) ? skip_q : shifted;
  assign ob_sub     = (phase_q == PH_BOXTYPE) ? 64'd8 : 64'd16;
  assign ob_ok      = ob_len >= ob_sub;
  assign ob_payload = ob_ok ? (ob_len - ob_sub) : 64'd0;
  assign csrem_dec  = (csrem_q != 64'd0) ? (csrem_q - 64'd1) : csrem_q;
  assign in_cs      = (phase_q == PH_MARKER) || (phase_q == PH_SEGLEN) ||
                      (phase_q == PH_SEGLEN_COD) || (phase_q == PH_SEGSKIP) ||
                      (phase_q == PH_CODBODY);

  // Next state of the walker and the status of this byte.
  always_comb begin
    phase_d    = phase_q;
    field_d    = field_q;
    cnt_d      = cnt_q;
    skip_d     = skip_q;
    csrem_d    = csrem_q;
    bounded_d  = bounded_q;
    lossless_d = lossless_q;
    decided_d  = decided_q;
    st_vld     = 1'b0;
    st         = ST_LOSSY;
    ob_do      = 1'b0;
    ob_cs      = 1'b0;
    ob_to_end  = 1'b0;

    if (!decided_q) begin
      unique case (phase_q)
        PH_START: begin
          field_d   = {56'd0, b};
          cnt_d     = 4'd1;
          bounded_d = 1'b0;
          phase_d   = (b == RAW_CS_BYTE) ? PH_MARKER : PH_BOXLEN;
        end
        PH_BOXLEN: begin
          field_d = shifted;
          cnt_d   = cnt_inc;
          if (cnt_inc == 4'd4) begin
            skip_d  = {32'd0, shifted[31:0]};
            field_d = '0;
            cnt_d   = '0;
            phase_d = PH_BOXTYPE;
          end
        end
        PH_BOXTYPE: begin
          field_d = shifted;
          cnt_d   = cnt_inc;
          if (cnt_inc == 4'd4) begin
            field_d = '0;
            cnt_d   = '0;
            if (skip_q == 64'd1) begin
              phase_d = (shifted[31:0] == BOX_JP2C) ? PH_XLEN_CS : PH_XLEN;
            end else begin
              ob_do     = 1'b1;
              ob_cs     = shifted[31:0] == BOX_JP2C;
              ob_to_end = skip_q == 64'd0;
            end
          end
        end
        PH_XLEN, PH_XLEN_CS: begin
          field_d = shifted;
          cnt_d   = cnt_inc;
          if (cnt_inc == 4'd8) begin
            field_d = '0;
            cnt_d   = '0;
            ob_do   = 1'b1;
            ob_cs   = phase_q == PH_XLEN_CS;
          end
        end
        PH_MARKER: begin
          field_d = shifted;
          cnt_d   = cnt_inc;
          if (cnt_inc == 4'd2) begin
            field_d = '0;
            cnt_d   = '0;
            if (no_length(low16)) begin
              if (low16 == MK_SOD) begin
                st_vld = 1'b1;
                st     = lossless_q ? ST_LOSSLESS : ST_LOSSY;
              end
            end else begin
              phase_d = (low16 == MK_COD) ? PH_SEGLEN_COD : PH_SEGLEN;
            end
          end
        end
        PH_SEGLEN, PH_SEGLEN_COD: begin
          field_d = shifted;
          cnt_d   = cnt_inc;
          if (cnt_inc == 4'd2) begin
            field_d = '0;
            cnt_d   = '0;
            if (low16 < 16'd2) begin
              st_vld = 1'b1;
              st     = ST_PARSE_ERR;
            end else if (phase_q == PH_SEGLEN_COD) begin
              if (seg_rem < 16'd10) begin
                st_vld = 1'b1;
                st     = ST_PARSE_ERR;
              end else begin
                skip_d  = {48'd0, seg_rem};
                phase_d = PH_CODBODY;
              end
            end else if (seg_rem == 16'd0) begin
              phase_d = PH_MARKER;
            end else begin
              skip_d  = {48'd0, seg_rem};
              phase_d = PH_SEGSKIP;
            end
          end
        end
        PH_BOXSKIP, PH_SEGSKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 64'd0) begin
            field_d = '0;
            cnt_d   = '0;
            phase_d = (phase_q == PH_BOXSKIP) ? PH_BOXLEN : PH_MARKER;
          end
        end
        PH_CODBODY: begin
          if ((cnt_q == 4'd9) && (b != XFORM_REV)) begin
            st_vld = 1'b1;
            st     = (b == XFORM_IRREV) ? ST_LOSSY : ST_UNKNOWN;
          end else begin
            if (cnt_q == 4'd9) begin
              lossless_d = 1'b1;
            end
            if (cnt_q < 4'd10) begin
              cnt_d = cnt_inc;
            end
            skip_d = skip_dec;
            if (skip_dec == 64'd0) begin
              field_d = '0;
              cnt_d   = '0;
              phase_d = PH_MARKER;
            end
          end
        end
        default: begin
        end
      endcase

      // Opening a box once its length and type are known.
      if (ob_do) begin
        if (ob_cs && ob_to_end) begin
          bounded_d = 1'b0;
          phase_d   = PH_MARKER;
        end else if (!ob_ok) begin
          st_vld = 1'b1;
          st     = ST_PARSE_ERR;
        end else if (ob_cs) begin
          bounded_d = 1'b1;
          csrem_d   = ob_payload;
          phase_d   = PH_MARKER;
          if (ob_payload == 64'd0) begin
            st_vld = 1'b1;
            st     = ST_PARSE_ERR;
          end
        end else begin
          skip_d  = ob_payload;
          phase_d = (ob_payload == 64'd0) ? PH_BOXLEN : PH_BOXSKIP;
        end
      end

      // A bounded codestream that runs out without a decision fails.
      if (!st_vld && in_cs && bounded_q) begin
        csrem_d = csrem_dec;
        if (csrem_dec == 64'd0) begin
          st_vld = 1'b1;
          st     = ST_PARSE_ERR;
        end
      end

      // The stream ended without a decision.
      if (!st_vld && last) begin
        st_vld = 1'b1;
        st     = ST_PARSE_ERR;
      end

      if (st_vld) begin
        decided_d = 1'b1;
        phase_d   = PH_DONE;
      end
    end

    // Every stream starts from the reset state.
    if (last) begin
      phase_d    = PH_START;
      field_d    = '0;
      cnt_d      = '0;
      skip_d     = '0;
      csrem_d    = '0;
      bounded_d  = 1'b0;
      lossless_d = 1'b0;
      decided_d  = 1'b0;
    end
  end

  assign res_o = '{valid: step_i && st_vld, status: st};

  // Walker state, updated once per consumed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      field_q    <= '0;
      cnt_q      <= '0;
      skip_q     <= '0;
      csrem_q    <= '0;
      bounded_q  <= 1'b0;
      lossless_q <= 1'b0;
      decided_q  <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      field_q    <= field_d;
      cnt_q      <= cnt_d;
      skip_q     <= skip_d;
      csrem_q    <= csrem_d;
      bounded_q  <= bounded_d;
      lossless_q <= lossless_d;
      decided_q  <= decided_d;
    end
  end

endmodule

@@ sv/jp2td_out_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector output stage
// Holds one status result until the sink takes it.
// ----------------------------------------------------------------------------
module jp2td_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jp2td_pkg::res_t res_i,
  output logic            free_o,
  jp2td_status_if.source  status_o
);
  import jp2td_pkg::*;

  logic       valid_q;
  logic [1:0] status_q;

  // Room for a new result when empty or when the held one transfers now.
  assign free_o          = !valid_q || status_o.ready;
  assign status_o.valid  = valid_q;
  assign status_o.status = status_q;

  // Valid flag of the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= res_i.valid;
    end
  end

  // Status payload, loaded only with a new result.
  always_ff @(posedge clk_i) begin
    if (free_o && res_i.valid) begin
      status_q <= res_i.status;
    end
  end

endmodule

@@ sv/jp2td_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector checker
// Port-level assertions on the byte and status channels.
// ----------------------------------------------------------------------------
`include "jpeg2000_transform_detector_macros.svh"

module jp2td_checker (
  input logic            clk_i,
  input logic            rst_ni,
  jp2td_byte_if.sink     byte_i,
  jp2td_status_if.source status_o
);

  // With the result register empty, the block always takes a byte.
  `JP2TD_ASSERT(a_ready_when_empty, (!status_o.valid |-> byte_i.ready), "byte not taken while empty")

  // No result can appear without a byte in flight.
  `JP2TD_ASSERT(a_no_result_from_nothing, ((!status_o.valid && !(byte_i.valid && byte_i.ready)) ##1 !status_o.valid |=> !status_o.valid), "result without a byte")

  // A stalled result stays valid and unchanged.
  `JP2TD_ASSERT_NEXT(a_stall_hold, status_o.valid && !status_o.ready, status_o.valid && $stable(status_o.status), "stalled result changed")

endmodule

bind jpeg2000_transform_detector jp2td_checker u_jp2td_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .byte_i   (byte_i),
  .status_o (status_o)
);

@@ dv/jpeg2000_transform_detector_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG 2000 transform detector testbench
// Sends raw codestreams, JP2 box files, damaged files and random noise
// through the byte channel. A byte-level software walker predicts the status
// of every stream, and the monitor compares each status transfer with the
// oldest prediction. Both channels idle at random, and the status side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module jpeg2000_transform_detector_tb;
  import jp2td_pkg::*;

  typedef logic [7:0] octet_q_t[$];

  localparam int          NO_STATUS    = -1;
  localparam int          IDLE_PCT     = 14;
  localparam int          LONG_STALL   = 200;
  localparam int          STALL_AFTER  = 12;
  localparam int          RANDOM_BYTES = 1850;
  localparam int          MIN_STREAMS  = 60;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          CALM_FROM    = 1200;
  localparam int          CALM_TO      = 1800;
  localparam logic [15:0] MK_SIZ       = 16'hFF51;
  localparam logic [15:0] MK_QCD       = 16'hFF5C;
  localparam logic [15:0] MK_COM       = 16'hFF64;
  localparam logic [31:0] BOX_FTYP     = 32'h66747970;

  logic clk_i;
  logic rst_ni;

  jp2td_byte_if   byte_ch ();
  jp2td_status_if status_ch ();

  jpeg2000_transform_detector u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_ch),
    .status_o(status_ch)
  );

  // Stimulus and scoreboard bookkeeping.
  item_t       byte_pend_q[$];
  logic [1:0]  status_expect_q[$];
  int unsigned bytes_total;
  int unsigned bytes_done;
  int unsigned streams_cnt;
  int unsigned results_seen;
  int unsigned error_cnt;
  int unsigned cycle_cnt;
  bit          byte_taken;
  logic        calm;

  // Walker state of the prediction.
  phase_e      ph;
  logic [63:0] shift_r;
  int unsigned nbytes;
  logic [63:0] skip_left;
  logic [63:0] cs_left;
  bit          cs_bounded;
  bit          rev_seen;
  bit          done_r;

  assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void field_clear();
    shift_r = '0;
    nbytes  = 0;
  endfunction

  function automatic void walker_reset();
    ph         = PH_START;
    skip_left  = '0;
    cs_left    = '0;
    cs_bounded = 1'b0;
    rev_seen   = 1'b0;
    done_r     = 1'b0;
    field_clear();
  endfunction

  // Opens a box once its header is complete.
  function automatic int enter_box(input bit is_cs, input bit to_end, input bit ok,
                                   input logic [63:0] payload);
    field_clear();
    if (is_cs && to_end) begin
      cs_bounded = 1'b0;
      ph = PH_MARKER;
      return NO_STATUS;
    end
    if (!ok) return ST_PARSE_ERR;
    if (is_cs) begin
      cs_bounded = 1'b1;
      cs_left = payload;
      ph = PH_MARKER;
      return (payload == 0) ? ST_PARSE_ERR : NO_STATUS;
    end
    skip_left = payload;
    if (payload == 0) ph = PH_BOXLEN;
    else ph = PH_BOXSKIP;
    return NO_STATUS;
  endfunction

  // Advances the walker by one byte of the file.
  function automatic int walk_byte(input logic [7:0] b);
    logic [63:0] len;
    logic [15:0] code;
    bit          is_cs;
    bit          is_cod;
    case (ph)
      PH_START: begin
        field_clear();
        shift_r = {56'd0, b};
        nbytes = 1;
        cs_bounded = 1'b0;
        if (b == RAW_CS_BYTE) ph = PH_MARKER;
        else ph = PH_BOXLEN;
        return NO_STATUS;
      end
      PH_BOXSKIP, PH_SEGSKIP: begin
        skip_left--;
        if (skip_left == 0) begin
          field_clear();
          if (ph == PH_BOXSKIP) ph = PH_BOXLEN;
          else ph = PH_MARKER;
        end
        return NO_STATUS;
      end
      PH_CODBODY: begin
        if (nbytes == 9) begin
          if (b == XFORM_IRREV) return ST_LOSSY;
          if (b != XFORM_REV) return ST_UNKNOWN;
          rev_seen = 1'b1;
        end
        if (nbytes < 10) nbytes++;
        skip_left--;
        if (skip_left == 0) begin
          field_clear();
          ph = PH_MARKER;
        end
        return NO_STATUS;
      end
      PH_DONE: return NO_STATUS;
      default: begin
        shift_r = {shift_r[55:0], b};
        nbytes++;
      end
    endcase

    // A header field has taken one more byte.
    case (ph)
      PH_BOXLEN: begin
        if (nbytes < 4) return NO_STATUS;
        skip_left = {32'd0, shift_r[31:0]};
        field_clear();
        ph = PH_BOXTYPE;
        return NO_STATUS;
      end
      PH_BOXTYPE: begin
        if (nbytes < 4) return NO_STATUS;
        is_cs = (shift_r[31:0] == BOX_JP2C);
        len = skip_left;
        if (len == 1) begin
          field_clear();
          if (is_cs) ph = PH_XLEN_CS;
          else ph = PH_XLEN;
          return NO_STATUS;
        end
        return enter_box(is_cs, len == 0, len >= 8, (len >= 8) ? len - 8 : '0);
      end
      PH_XLEN, PH_XLEN_CS: begin
        if (nbytes < 8) return NO_STATUS;
        len = shift_r;
        return enter_box(ph == PH_XLEN_CS, 1'b0, len >= 16, (len >= 16) ? len - 16 : '0);
      end
      PH_MARKER: begin
        if (nbytes < 2) return NO_STATUS;
        code = shift_r[15:0];
        field_clear();
        if ((code >= MK_RSV_LO && code <= MK_RSV_HI) || code == MK_SOC ||
            code == MK_SOD || code == MK_EOC || code == MK_EPH) begin
          if (code == MK_SOD) return rev_seen ? ST_LOSSLESS : ST_LOSSY;
          return NO_STATUS;
        end
        if (code == MK_COD) ph = PH_SEGLEN_COD;
        else ph = PH_SEGLEN;
        return NO_STATUS;
      end
      default: begin
        // Segment length of a marker segment.
        is_cod = (ph == PH_SEGLEN_COD);
        if (nbytes < 2) return NO_STATUS;
        len = {48'd0, shift_r[15:0]};
        field_clear();
        if (len < 2) return ST_PARSE_ERR;
        len -= 2;
        if (is_cod) begin
          if (len < 10) return ST_PARSE_ERR;
          skip_left = len;
          ph = PH_CODBODY;
          return NO_STATUS;
        end
        if (len == 0) begin
          ph = PH_MARKER;
          return NO_STATUS;
        end
        skip_left = len;
        ph = PH_SEGSKIP;
        return NO_STATUS;
      end
    endcase
  endfunction

  // Status caused by one accepted byte, or NO_STATUS.
  function automatic int predict_status(input logic [7:0] b, input bit last);
    int st;
    bit in_cs;
    st = NO_STATUS;
    if (!done_r) begin
      in_cs = (ph >= PH_MARKER) && (ph <= PH_CODBODY);
      st = walk_byte(b);
      if (st < 0 && in_cs && cs_bounded) begin
        if (cs_left > 0) cs_left--;
        if (cs_left == 0) st = ST_PARSE_ERR;
      end
      if (st < 0 && last) st = ST_PARSE_ERR;
      if (st >= 0) begin
        done_r = 1'b1;
        ph = PH_DONE;
      end
    end
    if (last) walker_reset();
    return st;
  endfunction

  // --------------------------------------------------------------------------
  // Stream construction
  // --------------------------------------------------------------------------

  task automatic put_be(ref octet_q_t q, input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back(v[8*i +: 8]);
  endtask

  task automatic add_segment(ref octet_q_t q, input logic [15:0] mk, input int plen);
    put_be(q, mk, 2);
    put_be(q, plen + 2, 2);
    repeat (plen) q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_cod(ref octet_q_t q, input int plen, input logic [7:0] xform);
    put_be(q, MK_COD, 2);
    put_be(q, plen + 2, 2);
    for (int i = 0; i < plen; i++) begin
      if (i == 9) q.push_back(xform);
      else q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Marker segments and bare markers that the walker passes over.
  task automatic add_filler(ref octet_q_t q);
    case ($urandom_range(0, 5))
      0: add_segment(q, MK_SIZ, $urandom_range(0, 5));
      1: add_segment(q, MK_QCD, $urandom_range(0, 3));
      2: add_segment(q, MK_COM, $urandom_range(0, 4));
      3: put_be(q, MK_RSV_LO + 16'($urandom_range(0, 15)), 2);
      4: put_be(q, MK_EPH, 2);
      default: put_be(q, MK_EOC, 2);
    endcase
  endtask

  task automatic build_codestream(ref octet_q_t q, input bit with_cod,
                                  input logic [7:0] xform, input int cod_len);
    put_be(q, MK_SOC, 2);
    repeat ($urandom_range(0, 2)) add_filler(q);
    if (with_cod) add_cod(q, cod_len, xform);
    repeat ($urandom_range(0, 1)) add_filler(q);
    put_be(q, MK_SOD, 2);
    repeat ($urandom_range(0, 3)) q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Wraps a codestream in up to two ordinary boxes and a jp2c box.
  task automatic build_jp2(ref octet_q_t q, input octet_q_t cs);
    logic [31:0] ty;
    int          plen;
    repeat ($urandom_range(0, 2)) begin
      ty = $urandom;
      if (ty == BOX_JP2C) ty ^= 32'd1;
      plen = $urandom_range(0, 6);
      if ($urandom_range(0, 4) == 0) begin
        put_be(q, 1, 4);
        put_be(q, ty, 4);
        put_be(q, 16 + plen, 8);
      end else begin
        put_be(q, 8 + plen, 4);
        put_be(q, ty, 4);
      end
      repeat (plen) q.push_back(8'($urandom_range(0, 255)));
    end
    case ($urandom_range(0, 3))
      0: begin
        put_be(q, 0, 4);
        put_be(q, BOX_JP2C, 4);
      end
      1: begin
        put_be(q, 8 + cs.size(), 4);
        put_be(q, BOX_JP2C, 4);
      end
      2: begin
        put_be(q, 1, 4);
        put_be(q, BOX_JP2C, 4);
        put_be(q, 16 + cs.size(), 8);
      end
      default: begin
        // Box no longer than its codestream.
        put_be(q, 8 + $urandom_range(1, cs.size()), 4);
        put_be(q, BOX_JP2C, 4);
      end
    endcase
    foreach (cs[i]) q.push_back(cs[i]);
  endtask

  // Queues a whole stream; its last byte carries end of stream.
  task automatic queue_stream(input octet_q_t s);
    item_t it;
    foreach (s[i]) begin
      it.byte_value = s[i];
      it.end_of_stream = (i == s.size() - 1);
      byte_pend_q.push_back(it);
    end
    bytes_total += s.size();
    streams_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Byte driver: one transfer at a time, new data at the falling edge.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    item_t cur;
    if (rst_ni) begin
      if (byte_taken || !byte_ch.valid) begin
        if (byte_pend_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur = byte_pend_q.pop_front();
          byte_ch.valid         <= 1'b1;
          byte_ch.byte_value    <= cur.byte_value;
          byte_ch.end_of_stream <= cur.end_of_stream;
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Status ready: random stalls and one long hold-off.
  always @(negedge clk_i) begin
    int unsigned stall_left;
    bit          stall_done;
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        status_ch.ready <= 1'b0;
      end else if (!stall_done && results_seen >= STALL_AFTER) begin
        stall_done = 1'b1;
        stall_left = LONG_STALL - 1;
        status_ch.ready <= 1'b0;
      end else begin
        status_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each byte transfer, checks each status transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    int         st;
    logic [1:0] exp_st;
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        byte_taken = 1'b1;
        bytes_done++;
        st = predict_status(byte_ch.byte_value, byte_ch.end_of_stream);
        if (st >= 0) status_expect_q.push_back(st[1:0]);
      end
      if (status_ch.valid && status_ch.ready) begin
        results_seen++;
        if (status_expect_q.size() == 0) begin
          error_cnt++;
          $display("%0t: status transfer with none expected: expected none, actual %0d",
                   $time, status_ch.status);
        end else begin
          exp_st = status_expect_q.pop_front();
          if (status_ch.status !== exp_st) begin
            error_cnt++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_st, status_ch.status);
          end
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    octet_q_t   s;
    octet_q_t   cs;
    int         kind;
    int         r;
    logic [7:0] xf;

    rst_ni                  = 1'b0;
    byte_ch.valid           = 1'b0;
    byte_ch.byte_value      = '0;
    byte_ch.end_of_stream   = 1'b0;
    status_ch.ready         = 1'b0;
    bytes_total             = 0;
    bytes_done              = 0;
    streams_cnt             = 0;
    results_seen            = 0;
    error_cnt               = 0;
    cycle_cnt               = 0;
    byte_taken              = 1'b0;
    walker_reset();

    // Raw codestreams: lossy, lossless, unknown transform, SOD with no COD.
    cs.delete(); build_codestream(cs, 1'b1, XFORM_IRREV, 10); queue_stream(cs);
    cs.delete(); build_codestream(cs, 1'b1, XFORM_REV, 10); queue_stream(cs);
    cs.delete(); build_codestream(cs, 1'b1, 8'hFF, 11); queue_stream(cs);
    cs.delete(); build_codestream(cs, 1'b0, XFORM_IRREV, 10); queue_stream(cs);

    // Segment length below two.
    s.delete(); put_be(s, MK_SOC, 2); put_be(s, MK_SIZ, 2); put_be(s, 1, 2);
    put_be(s, MK_SOD, 2); queue_stream(s);

    // COD segment one byte too short.
    s.delete(); put_be(s, MK_SOC, 2); add_cod(s, 9, XFORM_REV); put_be(s, MK_SOD, 2);
    queue_stream(s);

    // Short box, short extended length, and an open-ended ordinary box.
    s.delete(); put_be(s, 5, 4); put_be(s, BOX_FTYP, 4); put_be(s, 0, 2); queue_stream(s);
    s.delete(); put_be(s, 1, 4); put_be(s, BOX_FTYP, 4); put_be(s, 15, 8); queue_stream(s);
    s.delete(); put_be(s, 0, 4); put_be(s, BOX_FTYP, 4); put_be(s, 0, 2); queue_stream(s);

    // Open-ended jp2c box with a lossless codestream.
    s.delete(); cs.delete(); build_codestream(cs, 1'b1, XFORM_REV, 12);
    put_be(s, 0, 4); put_be(s, BOX_JP2C, 4);
    foreach (cs[i]) s.push_back(cs[i]);
    queue_stream(s);

    // Bounded jp2c box whose bytes run out before any decision.
    s.delete(); cs.delete(); build_codestream(cs, 1'b1, XFORM_IRREV, 12);
    put_be(s, 12, 4); put_be(s, BOX_JP2C, 4);
    foreach (cs[i]) s.push_back(cs[i]);
    queue_stream(s);

    // Largest extended length on jp2c, then a huge ordinary box cut by end of stream.
    s.delete(); cs.delete(); build_codestream(cs, 1'b1, XFORM_IRREV, 10);
    put_be(s, 1, 4); put_be(s, BOX_JP2C, 4); put_be(s, 64'hFFFF_FFFF_FFFF_FFFF, 8);
    foreach (cs[i]) s.push_back(cs[i]);
    queue_stream(s);
    s.delete(); put_be(s, 8, 4); put_be(s, BOX_FTYP, 4);
    put_be(s, 32'hFFFF_FFFF, 4); put_be(s, BOX_FTYP, 4); put_be(s, 0, 3); queue_stream(s);

    // End of stream with no decision on the very first byte.
    s.delete(); s.push_back(8'h00); queue_stream(s);
    s.delete(); s.push_back(RAW_CS_BYTE); queue_stream(s);

    // Random streams: mostly well formed, some damaged, some noise.
    while (bytes_total < RANDOM_BYTES || streams_cnt < MIN_STREAMS) begin
      s.delete();
      cs.delete();
      kind = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      if (r < 40) xf = XFORM_IRREV;
      else if (r < 80) xf = XFORM_REV;
      else xf = 8'($urandom_range(2, 255));
      build_codestream(cs, $urandom_range(0, 9) != 0, xf, $urandom_range(10, 13));
      if (kind < 40) begin
        s = cs;
      end else if (kind < 75) begin
        build_jp2(s, cs);
      end else if (kind < 90) begin
        if ($urandom_range(0, 1) != 0) build_jp2(s, cs);
        else s = cs;
        if ($urandom_range(0, 1) != 0) begin
          r = $urandom_range(1, s.size());
          while (s.size() > r) void'(s.pop_back());
        end else begin
          repeat ($urandom_range(1, 2)) s[$urandom_range(0, s.size() - 1)] =
              8'($urandom_range(0, 255));
        end
      end else begin
        repeat ($urandom_range(1, 24)) s.push_back(8'($urandom_range(0, 255)));
      end
      queue_stream(s);
    end

    // Reset is held, then released at a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_done < bytes_total || status_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (error_cnt == 0 && status_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
